// File: rtl/gmf_pkg.sv
package gmf_pkg;

  localparam int MAX_KERNEL_WIDTH  = 8;
  localparam int MAX_KERNEL_HEIGHT = 8;
  localparam int MAX_IMAGE_WIDTH   = 4096;
  localparam int MASK_SIDE         = 8;

  localparam logic [7:0] PIX_MAX = 8'd255;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_IMAGE_WIDTH);
  localparam int ROW_W     = 12;
  localparam int IMG_W_W   = COL_W + 1;
  localparam int KDIM_W    = 4;
  localparam int KOFF_W    = 3;
  localparam int LS_ROWS   = MAX_KERNEL_HEIGHT - 1;
  localparam int SLOT_W    = $clog2(LS_ROWS);
  localparam int LS_WORD_W = LS_ROWS * PIX_W;
  localparam int WIN_COL_W = MAX_KERNEL_HEIGHT * PIX_W;
  localparam int NPOS      = MAX_KERNEL_HEIGHT * MAX_KERNEL_WIDTH;
  localparam int MASK_W    = MASK_SIDE * MASK_SIDE;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ROW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_VALUE  = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] result;
    logic             position_valid;
    logic [11:0]      out_col;
    logic [11:0]      out_row;
  } pixel_out_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [LS_WORD_W-1:0] rows;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [SLOT_W-1:0]    slot;
  } column_t;

  typedef struct packed {
    logic              mode;
    logic [NPOS-1:0]   pos_mask;
    logic [PIX_W-1:0]  border;
    logic [KOFF_W-1:0] col_off;
    logic [KOFF_W-1:0] row_off;
  } win_cfg_t;

endpackage

// File: rtl/grayscale_morphology_filter.sv
// Grayscale erode/dilate over an 8-bit raster stream, one pixel per clock; a taken input beat
// passes the line-store stage, window stages s2 to s4 and the output register before its result
// is offered. The input stalls only when both the output register and its skid entry hold
// results that have not been taken. Each column address of a 4096-entry by 56-bit line
// memory holds the seven previous rows, read and written back once per pixel, with forwarding
// when consecutive pixels hit the same column. The line memory is not cleared after reset;
// every row is written before the window reads it.
module grayscale_morphology_filter import gmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pixel_in_t            pix,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pixel_out_t           res,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic              mode;
  logic [MASK_W-1:0] kernel_mask;
  logic [KDIM_W-1:0] kernel_width;
  logic [KDIM_W-1:0] kernel_height;
  logic [2:0]        anchor_col;
  logic [2:0]        anchor_row;
  logic [IMG_W_W-1:0] image_width;
  logic [PIX_W-1:0]  border_value;

  logic [KDIM_W-1:0]  kw;
  logic [KDIM_W-1:0]  kh;
  logic [KDIM_W-1:0]  ax;
  logic [KDIM_W-1:0]  ay;
  logic [IMG_W_W-1:0] img_width;
  win_cfg_t           wcfg_next;
  win_cfg_t           wcfg;

  logic       adv;
  logic       accept;
  logic       s1_valid;
  column_t    s1_item;
  logic       win_valid;
  pixel_out_t win_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 1'b0;
      kernel_mask   <= '1;
      kernel_width  <= KDIM_W'(3);
      kernel_height <= KDIM_W'(3);
      anchor_col    <= 3'd1;
      anchor_row    <= 3'd1;
      image_width   <= IMG_W_W'(640);
      border_value  <= PIX_MAX;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_MODE:          mode          <= cfg_data[0];
        REG_KERNEL_MASK:   kernel_mask   <= cfg_data[MASK_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KDIM_W-1:0];
        REG_ANCHOR_COL:    anchor_col    <= cfg_data[2:0];
        REG_ANCHOR_ROW:    anchor_row    <= cfg_data[2:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[IMG_W_W-1:0];
        REG_BORDER_VALUE:  border_value  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [KDIM_W-1:0] mi;
    logic [KDIM_W-1:0] mj;
    kw = (kernel_width == '0) ? KDIM_W'(1) :
         (kernel_width > KDIM_W'(MAX_KERNEL_WIDTH)) ? KDIM_W'(MAX_KERNEL_WIDTH) : kernel_width;
    kh = (kernel_height == '0) ? KDIM_W'(1) :
         (kernel_height > KDIM_W'(MAX_KERNEL_HEIGHT)) ? KDIM_W'(MAX_KERNEL_HEIGHT)
                                                       : kernel_height;
    ax = ({1'b0, anchor_col} < kw) ? {1'b0, anchor_col} : kw - KDIM_W'(1);
    ay = ({1'b0, anchor_row} < kh) ? {1'b0, anchor_row} : kh - KDIM_W'(1);
    img_width = (image_width == '0) ? IMG_W_W'(1) :
                (image_width > IMG_W_W'(MAX_IMAGE_WIDTH)) ? IMG_W_W'(MAX_IMAGE_WIDTH)
                                                           : image_width;
    wcfg_next.mode    = mode;
    wcfg_next.border  = border_value;
    wcfg_next.col_off = KOFF_W'(kw - KDIM_W'(1) - ax);
    wcfg_next.row_off = KOFF_W'(kh - KDIM_W'(1) - ay);
    for (int d = 0; d < MAX_KERNEL_HEIGHT; d++) begin
      for (int k = 0; k < MAX_KERNEL_WIDTH; k++) begin
        mi = kh - KDIM_W'(1) - KDIM_W'(d);
        mj = kw - KDIM_W'(1) - KDIM_W'(k);
        wcfg_next.pos_mask[d*MAX_KERNEL_WIDTH + k] =
          (KDIM_W'(d) < kh) && (KDIM_W'(k) < kw) && kernel_mask[{mi[2:0], mj[2:0]}];
      end
    end
  end

  always_ff @(posedge clk) begin
    wcfg <= wcfg_next;
  end

  assign pix_ready = adv;
  assign accept    = pix_valid && pix_ready;

  gmf_line_store u_line_store (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .accept    (accept),
    .pix       (pix),
    .img_width (img_width),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  gmf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .wcfg      (wcfg),
    .res_valid (win_valid),
    .res       (win_res)
  );

  gmf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && win_valid),
    .push_data (win_res),
    .can_push  (adv),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// File: rtl/gmf_line_store.sv
module gmf_line_store import gmf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               accept,
  input  pixel_in_t          pix,
  input  logic [IMG_W_W-1:0] img_width,
  output logic               s1_valid,
  output column_t            s1_item
);

  logic [LS_WORD_W-1:0] mem [MAX_IMAGE_WIDTH];
  logic [LS_WORD_W-1:0] rdata;
  logic [LS_WORD_W-1:0] fwd_data;
  logic                 fwd_hit;
  logic [LS_WORD_W-1:0] rows_now;
  logic [LS_WORD_W-1:0] merged;
  logic                 wr_en;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [SLOT_W-1:0]  slot;
  logic               started;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [IMG_W_W-1:0] col_inc;

  logic [PIX_W-1:0]  s1_pixel;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [SLOT_W-1:0] s1_slot;

  always_comb begin
    col_inc = {1'b0, col} + IMG_W_W'(1);
    if (pix.frame_start || !started) begin
      col_next  = '0;
      row_next  = '0;
      slot_next = '0;
    end else if (col_inc >= img_width) begin
      col_next  = '0;
      row_next  = row + ROW_W'(1);
      slot_next = (slot == SLOT_W'(LS_ROWS - 1)) ? '0 : slot + SLOT_W'(1);
    end else begin
      col_next  = col_inc[COL_W-1:0];
      row_next  = row;
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      slot    <= '0;
      started <= 1'b0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      slot    <= slot_next;
      started <= 1'b1;
    end
  end

  assign wr_en    = adv && s1_valid;
  assign rows_now = fwd_hit ? fwd_data : rdata;

  always_comb begin
    for (int s = 0; s < LS_ROWS; s++) begin
      merged[s*PIX_W +: PIX_W] = (s1_slot == SLOT_W'(s)) ? s1_pixel
                                                         : rows_now[s*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[col_next];
    end
    if (wr_en) begin
      mem[s1_col] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      fwd_hit  <= wr_en && (s1_col == col_next);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= merged;
      s1_pixel <= pix.pixel;
      s1_col   <= col_next;
      s1_row   <= row_next;
      s1_slot  <= slot_next;
    end
  end

  assign s1_item = '{pixel: s1_pixel, rows: rows_now, col: s1_col, row: s1_row,
                     slot: s1_slot};

`ifndef SYNTHESIS
  a_frame_origin: assert property (@(posedge clk) disable iff (rst)
    accept && pix.frame_start |=> s1_valid && s1_col == '0 && s1_row == '0 && s1_slot == '0)
    else $error("frame start did not restart the raster position");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> {1'b0, s1_col} < img_width)
    else $error("column position beyond the image width");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_item))
    else $error("line store stage changed while stalled");
`endif

endmodule

// File: rtl/gmf_window.sv
module gmf_window import gmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       s1_valid,
  input  column_t    s1_item,
  input  win_cfg_t   wcfg,
  output logic       res_valid,
  output pixel_out_t res
);

  function automatic logic [PIX_W-1:0] pick(input logic dilate, input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    if (dilate) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

  logic [WIN_COL_W-1:0] win [MAX_KERNEL_WIDTH];

  logic              s2_valid;
  logic [COL_W-1:0]  s2_col;
  logic [ROW_W-1:0]  s2_row;
  logic [SLOT_W-1:0] s2_slot;

  logic [PIX_W-1:0] vals_next [MAX_KERNEL_HEIGHT][MAX_KERNEL_WIDTH];
  logic [PIX_W-1:0] vals      [MAX_KERNEL_HEIGHT][MAX_KERNEL_WIDTH];
  logic             s3_valid;
  logic             s3_pos_valid;
  logic [COL_W-1:0] s3_ocol;
  logic [ROW_W-1:0] s3_orow;

  logic [PIX_W-1:0] row_acc_next [MAX_KERNEL_HEIGHT];
  logic [PIX_W-1:0] row_acc      [MAX_KERNEL_HEIGHT];
  logic             s4_valid;
  logic             s4_pos_valid;
  logic [COL_W-1:0] s4_ocol;
  logic [ROW_W-1:0] s4_orow;
  logic [PIX_W-1:0] final_acc;

  logic [PIX_W-1:0] ident;
  assign ident = wcfg.mode ? '0 : PIX_MAX;

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      win[0] <= {s1_item.pixel, s1_item.rows};
      for (int k = 1; k < MAX_KERNEL_WIDTH; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  always_comb begin
    logic [SLOT_W:0]   t;
    logic [SLOT_W-1:0] sidx;
    logic [PIX_W-1:0]  b;
    for (int d = 0; d < MAX_KERNEL_HEIGHT; d++) begin
      t = {1'b0, s2_slot} + (SLOT_W + 1)'(LS_ROWS) - (SLOT_W + 1)'(d);
      if (t >= (SLOT_W + 1)'(LS_ROWS)) begin
        t = t - (SLOT_W + 1)'(LS_ROWS);
      end
      sidx = t[SLOT_W-1:0];
      for (int k = 0; k < MAX_KERNEL_WIDTH; k++) begin
        if (d == 0) begin
          b = win[k][LS_WORD_W +: PIX_W];
        end else begin
          b = win[k][sidx*PIX_W +: PIX_W];
        end
        if (!wcfg.pos_mask[d*MAX_KERNEL_WIDTH + k]) begin
          vals_next[d][k] = ident;
        end else if ((ROW_W'(d) > s2_row) || (COL_W'(k) > s2_col)) begin
          vals_next[d][k] = wcfg.border;
        end else begin
          vals_next[d][k] = b;
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_KERNEL_HEIGHT; d++) begin
      row_acc_next[d] = ident;
      for (int k = 0; k < MAX_KERNEL_WIDTH; k++) begin
        row_acc_next[d] = pick(wcfg.mode, row_acc_next[d], vals[d][k]);
      end
    end
  end

  always_comb begin
    final_acc = ident;
    for (int d = 0; d < MAX_KERNEL_HEIGHT; d++) begin
      final_acc = pick(wcfg.mode, final_acc, row_acc[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col       <= s1_item.col;
      s2_row       <= s1_item.row;
      s2_slot      <= s1_item.slot;
      vals         <= vals_next;
      s3_pos_valid <= (s2_row >= ROW_W'(wcfg.row_off)) && (s2_col >= COL_W'(wcfg.col_off));
      s3_ocol      <= s2_col - COL_W'(wcfg.col_off);
      s3_orow      <= s2_row - ROW_W'(wcfg.row_off);
      row_acc      <= row_acc_next;
      s4_pos_valid <= s3_pos_valid;
      s4_ocol      <= s3_ocol;
      s4_orow      <= s3_orow;
    end
  end

  assign res_valid = s4_valid;

  always_comb begin
    if (s4_pos_valid) begin
      res = '{result: final_acc, position_valid: 1'b1, out_col: s4_ocol, out_row: s4_orow};
    end else begin
      res = '0;
    end
  end

`ifndef SYNTHESIS
  a_empty_erode: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.position_valid && !wcfg.mode && wcfg.pos_mask == '0
    |-> res.result == PIX_MAX)
    else $error("erode with an empty element must give the top value");

  a_empty_dilate: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.position_valid && wcfg.mode && wcfg.pos_mask == '0
    |-> res.result == '0)
    else $error("dilate with an empty element must give zero");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !adv |=> s4_valid && $stable(res))
    else $error("final stage changed while stalled");
`endif

endmodule

// File: rtl/gmf_out_buf.sv
module gmf_out_buf import gmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pixel_out_t push_data,
  output logic       can_push,
  output logic       res_valid,
  input  logic       res_ready,
  output pixel_out_t res
);

  logic       skid_valid;
  pixel_out_t skid_data;
  logic       pop;

  assign pop      = res_valid && res_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (res_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res <= skid_data;
      end
    end else if (push) begin
      if (res_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        res <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("beat pushed into a full output buffer");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held with an empty output register");

  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !res_ready |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while the output stalled");
`endif

endmodule

// File: sim/morph_checker.sv
module morph_checker import gmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  input  logic                 pix_ready,
  input  pixel_in_t            pix,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  pixel_out_t           res,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   outstanding,
  output int                   mismatches,
  output int                   results_seen
);

  logic [PIX_W-1:0] line_mem [MAX_KERNEL_HEIGHT*MAX_IMAGE_WIDTH];
  int col_pos;
  int row_pos;
  int slot_ptr;
  bit started;

  logic               cf_mode;
  logic [MASK_W-1:0]  cf_mask;
  logic [KDIM_W-1:0]  cf_kw;
  logic [KDIM_W-1:0]  cf_kh;
  logic [KOFF_W-1:0]  cf_ax;
  logic [KOFF_W-1:0]  cf_ay;
  logic [IMG_W_W-1:0] cf_width;
  logic [PIX_W-1:0]   cf_border;

  pixel_out_t filtered_q [$];
  pixel_out_t want;
  int fail_count;
  int seen_count;

  // Advances the raster position, stores the pixel and folds the masked window
  // into a minimum or maximum for the anchored position.
  function automatic pixel_out_t morph_step(input pixel_in_t beat);
    int w, kw, kh, ax, ay, acc, rr, cc, srow, v, orow, ocol;
    pixel_out_t o;
    w  = (cf_width == 0) ? 1 :
         (cf_width > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH : int'(cf_width);
    kw = (cf_kw == 0) ? 1 : (cf_kw > MAX_KERNEL_WIDTH) ? MAX_KERNEL_WIDTH : int'(cf_kw);
    kh = (cf_kh == 0) ? 1 : (cf_kh > MAX_KERNEL_HEIGHT) ? MAX_KERNEL_HEIGHT : int'(cf_kh);
    ax = (int'(cf_ax) < kw) ? int'(cf_ax) : kw - 1;
    ay = (int'(cf_ay) < kh) ? int'(cf_ay) : kh - 1;
    acc = cf_mode ? 0 : int'(PIX_MAX);
    if (beat.frame_start || !started) begin
      col_pos = 0;
      row_pos = 0;
      slot_ptr = 0;
      started = 1'b1;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) % (1 << ROW_W);
        slot_ptr = (slot_ptr + 1) % MAX_KERNEL_HEIGHT;
      end
    end
    line_mem[slot_ptr*MAX_IMAGE_WIDTH + col_pos] = beat.pixel;
    for (int i = 0; i < kh; i++) begin
      rr = row_pos - (kh - 1 - i);
      srow = (slot_ptr + MAX_KERNEL_HEIGHT - (kh - 1 - i)) % MAX_KERNEL_HEIGHT;
      for (int j = 0; j < kw; j++) begin
        cc = col_pos - (kw - 1 - j);
        if (cf_mask[i*MASK_SIDE + j]) begin
          v = (rr < 0 || cc < 0) ? int'(cf_border) : int'(line_mem[srow*MAX_IMAGE_WIDTH + cc]);
          if (cf_mode ? (v > acc) : (v < acc)) acc = v;
        end
      end
    end
    orow = row_pos - (kh - 1 - ay);
    ocol = col_pos - (kw - 1 - ax);
    o = '0;
    if (orow >= 0 && ocol >= 0) begin
      o.result = acc[PIX_W-1:0];
      o.position_valid = 1'b1;
      o.out_col = ocol[11:0];
      o.out_row = orow[11:0];
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      slot_ptr = 0;
      started = 1'b0;
      cf_mode = 1'b0;
      cf_mask = '1;
      cf_kw = 4'd3;
      cf_kh = 4'd3;
      cf_ax = 3'd1;
      cf_ay = 3'd1;
      cf_width = 13'd640;
      cf_border = 8'd255;
      filtered_q.delete();
    end else begin
      // A result beat can never belong to a pixel beat of the same edge.
      if (res_valid && res_ready) begin
        seen_count++;
        if (filtered_q.size() == 0) begin
          if (fail_count < 10)
            $display("Unexpected result beat %0d: result=%0d valid=%0b col=%0d row=%0d",
                     seen_count, res.result, res.position_valid, res.out_col, res.out_row);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (res.result !== want.result || res.position_valid !== want.position_valid ||
              res.out_col !== want.out_col || res.out_row !== want.out_row) begin
            if (fail_count < 10)
              $display({"Result beat %0d mismatch: expected result=%0d valid=%0b col=%0d",
                        " row=%0d, got result=%0d valid=%0b col=%0d row=%0d"},
                       seen_count, want.result, want.position_valid, want.out_col,
                       want.out_row, res.result, res.position_valid, res.out_col,
                       res.out_row);
            fail_count++;
          end
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_MODE:          cf_mode = cfg_data[0];
          REG_KERNEL_MASK:   cf_mask = cfg_data[MASK_W-1:0];
          REG_KERNEL_WIDTH:  cf_kw = cfg_data[KDIM_W-1:0];
          REG_KERNEL_HEIGHT: cf_kh = cfg_data[KDIM_W-1:0];
          REG_ANCHOR_COL:    cf_ax = cfg_data[KOFF_W-1:0];
          REG_ANCHOR_ROW:    cf_ay = cfg_data[KOFF_W-1:0];
          REG_IMAGE_WIDTH:   cf_width = cfg_data[IMG_W_W-1:0];
          REG_BORDER_VALUE:  cf_border = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) filtered_q.push_back(morph_step(pix));
    end
    outstanding <= filtered_q.size();
    mismatches <= fail_count;
    results_seen <= seen_count;
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import gmf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PIXELS = 1200;
  localparam int DRAIN_CYCLES  = 20;

  logic                 clk;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_ready;
  pixel_in_t            pix;
  logic                 res_valid;
  logic                 res_ready;
  pixel_out_t           res;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   outstanding;
  int                   mismatches;
  int                   results_seen;

  int burst_left;
  int gap_max;
  int sent_count;
  int setting_count;
  int random_count;
  int stall_pct;
  int stall_hold;

  grayscale_morphology_filter dut (.*);

  morph_checker morph_chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      case ($urandom_range(4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_hold = $urandom_range(16, 200);
    end
    stall_hold--;
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, outstanding);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_valid <= 1'b1;
    pix.pixel <= value;
    pix.frame_start <= first;
    do @(posedge clk); while (!pix_ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_filter(input logic m, input logic [MASK_W-1:0] mask,
                                input logic [KDIM_W-1:0] kw, input logic [KDIM_W-1:0] kh,
                                input logic [KOFF_W-1:0] ax, input logic [KOFF_W-1:0] ay,
                                input logic [IMG_W_W-1:0] w, input logic [PIX_W-1:0] border);
    logic [CFG_W-1:0]     junk;
    logic [CFG_IDX_W-1:0] idx;
    wait_drained();
    // Bits above a register's width carry noise in about half the loads.
    junk = $urandom_range(1) ? {$urandom(), $urandom()} : '0;
    for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
      idx = CFG_IDX_W'(r);
      cfg_write_en <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_MODE:          cfg_data <= {junk[CFG_W-1:1], m};
        REG_KERNEL_MASK:   cfg_data <= mask;
        REG_KERNEL_WIDTH:  cfg_data <= {junk[CFG_W-1:KDIM_W], kw};
        REG_KERNEL_HEIGHT: cfg_data <= {junk[CFG_W-1:KDIM_W], kh};
        REG_ANCHOR_COL:    cfg_data <= {junk[CFG_W-1:KOFF_W], ax};
        REG_ANCHOR_ROW:    cfg_data <= {junk[CFG_W-1:KOFF_W], ay};
        REG_IMAGE_WIDTH:   cfg_data <= {junk[CFG_W-1:IMG_W_W], w};
        default:           cfg_data <= {junk[CFG_W-1:PIX_W], border};
      endcase
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    burst_left = 0;
    setting_count++;
  endtask

  initial begin
    logic               m;
    logic [MASK_W-1:0]  mask;
    logic [KDIM_W-1:0]  kw;
    logic [KDIM_W-1:0]  kh;
    logic [KOFF_W-1:0]  ax;
    logic [KOFF_W-1:0]  ay;
    logic [IMG_W_W-1:0] w;
    logic [IMG_W_W-1:0] w2;
    logic [PIX_W-1:0]   border;
    int                 eff_w;
    int                 n;
    int                 n2;
    int                 c;
    bit                 split;

    rst <= 1'b1;
    pix_valid <= 1'b0;
    pix <= '0;
    res_ready <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    gap_max = 0;
    burst_left = 0;

    // With reset settings, the very first beat carries no frame start.
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h01, 1'b1);

    // Empty mask in erode, zero sizes and width, anchors past the element.
    program_filter(1'b0, '0, 4'd0, 4'd0, 3'd7, 3'd7, 13'd0, 8'd0);
    for (int i = 0; i < 4; i++) send_pixel(i[0] ? 8'h00 : 8'hFF, i == 0);

    // Oversized element in dilate, anchored at its far corner.
    program_filter(1'b1, '1, 4'd15, 4'd9, 3'd7, 3'd7, 13'd3, 8'h5A);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? 8'hFF : 8'h00, i == 0);

    // Empty mask in dilate.
    program_filter(1'b1, '0, 4'd2, 4'd2, 3'd0, 3'd0, 13'd2, 8'hFF);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(), i == 0);

    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      m = 1'($urandom_range(1));
      case ($urandom_range(5))
        0:       mask = '1;
        1:       mask = '0;
        2:       mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
        default: mask = {$urandom(), $urandom()};
      endcase
      kw = KDIM_W'(($urandom_range(7) == 0) ? $urandom_range(15)
                                             : $urandom_range(1, MAX_KERNEL_WIDTH));
      kh = KDIM_W'(($urandom_range(7) == 0) ? $urandom_range(15)
                                             : $urandom_range(1, MAX_KERNEL_HEIGHT));
      ax = KOFF_W'($urandom_range(7));
      ay = KOFF_W'($urandom_range(7));
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = IMG_W_W'($urandom_range(21, 70));
        default: w = IMG_W_W'($urandom_range(1, 20));
      endcase
      border = ($urandom_range(3) == 0) ? (m ? 8'h00 : 8'hFF) : rand_pixel();
      eff_w = (w == 0) ? 1 : int'(w);
      split = (eff_w >= 3) && ($urandom_range(3) == 0);
      gap_max = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
      program_filter(m, mask, kw, kh, ax, ay, w, border);
      if (split) begin
        // Narrow the image mid-frame while the last column lies past the new width.
        c = $urandom_range(2, eff_w);
        n = eff_w * $urandom_range(1, 4) + c;
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(), i == 0);
        w2 = IMG_W_W'($urandom_range(1, c - 1));
        program_filter(m, mask, kw, kh, ax, ay, w2, border);
        n2 = int'(w2) * $urandom_range(2, 6) + $urandom_range(0, w2);
        for (int i = 0; i < n2; i++) send_pixel(rand_pixel(), 1'b0);
        random_count += n + n2;
      end else begin
        n = eff_w * $urandom_range(2, 10) + $urandom_range(0, eff_w);
        if (n > 200) n = 200;
        for (int i = 0; i < n; i++)
          send_pixel(rand_pixel(), (i == 0) || ($urandom_range(63) == 0));
        random_count += n;
      end
    end

    // A width at or just above the limit saturates to a full line, so no row ends early.
    m = 1'($urandom_range(1));
    gap_max = 0;
    program_filter(m, '1, 4'd8, 4'd2, 3'd7, 3'd1,
                   IMG_W_W'(MAX_IMAGE_WIDTH + $urandom_range(0, 150)),
                   rand_pixel());
    for (int i = 0; i < 200; i++) send_pixel(rand_pixel(), i == 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixel beats under %0d filter settings and checked %0d result beats.",
             sent_count, setting_count, results_seen);
    $display("Covered both modes, empty and sparse masks, clamped sizes, a saturated width");
    $display("and a mid-frame width cut; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gmf_pkg.sv
rtl/gmf_line_store.sv
rtl/gmf_window.sv
rtl/gmf_out_buf.sv
rtl/grayscale_morphology_filter.sv
sim/morph_checker.sv
sim/tb_top.sv
